@@ hdl/ctm_pkg.sv @@
// Shared types, constants and helpers for the concave table ternary maximum block.
// No dependencies; every other file imports this package.
package ctm_pkg;

	localparam int IDX_W           = 11;
	localparam int VAL_W           = 32;
	localparam int RES_W           = 64;
	localparam int PROD_W          = VAL_W + IDX_W + 1;
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int SCAN_SPAN       = 4;
	localparam int DIV3_MUL        = 43691;
	localparam int DIV3_SHIFT      = 17;
	localparam int DIV3_PW         = IDX_W + 2 + DIV3_SHIFT;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] data;
	} tbl_wr_t;

	// floor(x / 3) by reciprocal multiply; exact while the quotient fits IDX_W bits (x below 6144)
	function automatic logic [IDX_W-1:0] div3(input logic [IDX_W+1:0] x);
		logic [DIV3_PW-1:0] p;
		p = DIV3_PW'(x) * DIV3_PW'(DIV3_MUL);
		return p[DIV3_SHIFT +: IDX_W];
	endfunction

endpackage

@@ hdl/ctm_if.sv @@
// Valid/ready channel interfaces for commands and results.
// Depends on ctm_pkg for field widths.
interface ctm_cmd_if import ctm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [0:0]              op;
	logic [IDX_W-1:0]        sample_index;
	logic signed [VAL_W-1:0] sample_value;
	logic signed [VAL_W-1:0] slope;
	logic signed [VAL_W-1:0] offset;

	modport source (output valid, op, sample_index, sample_value, slope, offset, input ready);
	modport sink   (input valid, op, sample_index, sample_value, slope, offset, output ready);
endinterface

interface ctm_rsp_if import ctm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] max_value;

	modport source (output valid, max_value, input ready);
	modport sink   (input valid, max_value, output ready);
endinterface

@@ hdl/ctm_table.sv @@
// Sample memory: one write port, one registered read port.
// Depends on ctm_pkg; indices are 1-based and mapped to 0-based addresses here.
module ctm_table import ctm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                    clk,
	input  tbl_wr_t                 wr,
	input  logic [IDX_W-1:0]        rd_idx,
	output logic signed [VAL_W-1:0] rd_data
);
	localparam int AW = $clog2(TABLE_DEPTH);

	logic [VAL_W-1:0] mem [TABLE_DEPTH];
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_q;

	assign wr_addr = AW'(32'(wr.idx) - 32'd1);
	assign rd_addr = AW'(32'(rd_idx) - 32'd1);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = $signed(rd_q);
endmodule

@@ hdl/ctm_term.sv @@
// Shared term unit: f(i) - a*i - b, product registered, subtract on the next cycle.
// Depends on ctm_pkg; the sample arrives from the registered table read.
module ctm_term import ctm_pkg::*; (
	input  logic                    clk,
	input  logic [IDX_W-1:0]        idx,
	input  logic signed [VAL_W-1:0] slope,
	input  logic signed [VAL_W-1:0] offset,
	input  logic signed [VAL_W-1:0] sample,
	output logic signed [RES_W-1:0] term
);
	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(slope) * PROD_W'($signed({1'b0, idx}));
	end

	assign term = RES_W'(sample) - RES_W'(prod_s1) - RES_W'(offset);
endmodule

@@ hdl/concave_table_ternary_max.sv @@
// Top level of the concave table ternary maximum block: sequencer and output register.
// Depends on ctm_pkg, ctm_if, ctm_table and ctm_term.
//
// Usage:
//   cmd carries load and query items; a transfer takes place when valid and ready are high.
//   A load (op 0) writes sample_value at sample_index (1..TABLE_DEPTH) in the transfer
//   cycle; cmd stays ready while idle, so loads stream at one per cycle. Other indices
//   are ignored. A query (op 1) searches indices 1..N, N being sample_count clamped to
//   1..TABLE_DEPTH. cmd.ready falls while a query runs. Each search round steps through
//   split, two table reads through the one term unit, and compare; rounds run until the
//   span is at most 4, about log1.5(N/4) rounds, then a scan of the k <= 5 remaining
//   entries, ending in a final fold step. The next query can transfer in the same cycle
//   that rsp.valid rises. The result sits in an output register; cmd is ready again
//   once it is loaded, and a following query waits at its last step while rsp is
//   stalled. The user must write sample_count through cfg_we/cfg_wdata only while the
//   block is idle; the block itself does not enforce this.
//   Reset clears the sequencer, the output valid and sets sample_count to 1; the table
//   contents are undefined until loaded.
module concave_table_ternary_max import ctm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_wdata,
	ctm_cmd_if.sink          cmd,
	ctm_rsp_if.source        rsp
);
	localparam logic [31:0]      DEPTH_W  = 32'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] DEPTH_IW = IDX_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] SPAN_IW  = IDX_W'(SCAN_SPAN);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_SPLIT    = 8'b0000_0010,
		ST_RD_S     = 8'b0000_0100,
		ST_RD_T     = 8'b0000_1000,
		ST_CMP      = 8'b0001_0000,
		ST_SCAN     = 8'b0010_0000,
		ST_SCAN_END = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        count_q;
	logic [IDX_W-1:0]        lp_q, rp_q, s_q, t_q, idx_q;
	logic signed [VAL_W-1:0] slope_q, offset_q;
	logic signed [RES_W-1:0] term_s_q, best_q, out_q;
	logic                    best_v_q, pend_q, out_valid_q;

	logic                    cmd_xfer;
	logic [IDX_W-1:0]        n_clamp;
	logic [IDX_W-1:0]        issue_idx;
	logic signed [VAL_W-1:0] sample;
	logic signed [RES_W-1:0] term;
	logic                    fold_take;
	tbl_wr_t                 wr;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;

	always_comb begin
		if (count_q == '0) begin
			n_clamp = IDX_W'(1);
		end else if (32'(count_q) > DEPTH_W) begin
			n_clamp = DEPTH_IW;
		end else begin
			n_clamp = count_q;
		end
	end

	always_comb begin
		wr.en   = cmd_xfer && (cmd.op == OP_LOAD) && (cmd.sample_index != '0)
			&& (32'(cmd.sample_index) <= DEPTH_W);
		wr.idx  = cmd.sample_index;
		wr.data = cmd.sample_value;
	end

	always_comb begin
		case (state_q)
			ST_RD_S: issue_idx = s_q;
			ST_RD_T: issue_idx = t_q;
			default: issue_idx = idx_q;
		endcase
	end

	ctm_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_idx  (issue_idx),
		.rd_data (sample)
	);

	ctm_term u_term (
		.clk    (clk),
		.idx    (issue_idx),
		.slope  (slope_q),
		.offset (offset_q),
		.sample (sample),
		.term   (term)
	);

	assign fold_take = !best_v_q || (term > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= IDX_W'(1);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.valid && rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			best_v_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_xfer && cmd.op == OP_QUERY) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if ((rp_q - lp_q) > SPAN_IW) begin
						state_q <= ST_RD_S;
					end else begin
						pend_q   <= 1'b0;
						best_v_q <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_RD_S: state_q <= ST_RD_T;
				ST_RD_T: state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_SPLIT;
				ST_SCAN: begin
					pend_q <= 1'b1;
					if (pend_q) begin
						best_v_q <= 1'b1;
					end
					if (idx_q == rp_q) begin
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END: begin
					best_v_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_xfer && cmd.op == OP_QUERY) begin
					slope_q  <= cmd.slope;
					offset_q <= cmd.offset;
					lp_q     <= IDX_W'(1);
					rp_q     <= n_clamp;
				end
			end
			ST_SPLIT: begin
				s_q   <= div3({1'b0, lp_q, 1'b0} + {2'b00, rp_q});
				t_q   <= div3({2'b00, lp_q} + {1'b0, rp_q, 1'b0});
				idx_q <= lp_q;
			end
			ST_RD_T: term_s_q <= term;
			ST_CMP: begin
				if (term_s_q < term) begin
					lp_q <= s_q;
				end else begin
					rp_q <= t_q;
				end
			end
			ST_SCAN: begin
				idx_q <= idx_q + IDX_W'(1);
				if (pend_q && fold_take) begin
					best_q <= term;
				end
			end
			ST_SCAN_END: begin
				if (fold_take) begin
					best_q <= term;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_q <= best_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.max_value = out_q;

`ifndef NO_ASSERTIONS
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_SPLIT && !$past(state_q == ST_IDLE))
			|-> (lp_q <= rp_q))
		else $error("search bounds crossed");

	a_scan_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((rp_q - lp_q) <= SPAN_IW && idx_q <= rp_q))
		else $error("scan range too wide or index past upper bound");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion step");

	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_xfer && cmd.op == OP_QUERY) |=> !cmd.ready)
		else $error("command accepted while query in progress");
`endif
endmodule
